/* rtl/bicp_pkg.sv */
// ----------------------------------------------------------------------------
// bicp_pkg
// Types and constants for the binary image compare / projection block.
// ----------------------------------------------------------------------------
package bicp_pkg;

   localparam int MAX_ROWS    = 128;
   localparam int MAX_COLS    = 128;
   localparam int POS_WIDTH   = 7;
   localparam int COUNT_WIDTH = 8;
   localparam int SUM_WIDTH   = 8;
   localparam int COL_DEPTH   = 2 ** POS_WIDTH;
   localparam int CSR_IDX_WIDTH = 2;

   localparam int ROW_LIMIT = (MAX_ROWS < 128) ? MAX_ROWS : 128;
   localparam int COL_LIMIT = (MAX_COLS < 128) ? MAX_COLS : 128;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ROW_COUNT    = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_COL_COUNT    = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CHECKER_MODE = 2'd2;

   typedef struct packed {
      logic pixel_a;
      logic pixel_b;
   } req_type;

   typedef struct packed {
      logic                   a_used;
      logic                   union_bit;
      logic                   diff_bit;
      logic                   frame_last;
      logic                   images_equal;
      logic [COUNT_WIDTH-1:0] best_row;
      logic [COUNT_WIDTH-1:0] best_col;
   } rsp_type;

   // count register of 0 acts as 1, large values saturate
   function automatic logic [COUNT_WIDTH-1:0] clamp_count(
      input logic [COUNT_WIDTH-1:0] cfg,
      input logic [COUNT_WIDTH-1:0] top
   );
      logic [COUNT_WIDTH-1:0] res;
      if (cfg == '0) begin
         res = COUNT_WIDTH'(1);
      end else if (cfg > top) begin
         res = top;
      end else begin
         res = cfg;
      end
      return res;
   endfunction

endpackage

/* rtl/binary_image_compare_projection.sv */
// ----------------------------------------------------------------------------
// binary_image_compare_projection
// Pixel-pair compare with row / column projection argmax over a frame.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    req_data   (req_type)
//   rsp      out  rsp_valid/rsp_ready    rsp_data   (rsp_type)
//   csr      in   csr_valid/csr_ready    csr_index, csr_data
//
// One request per clock unless rsp stalls; a stalled rsp holds one result
// in the output register, a second request waits in the RAM stage. Column
// sums live in a 128x8 RAM, read on accept and written back as the item
// leaves the RAM stage; the last write is forwarded for back-to-back hits.
// Synchronous reset clears control and frame state; the RAM is not cleared,
// the first row of each frame initializes it. csr_ready is always high.
// ----------------------------------------------------------------------------
module binary_image_compare_projection
   import bicp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [COUNT_WIDTH-1:0]   csr_data
);

   // configuration
   logic [COUNT_WIDTH-1:0] row_count_ff, row_count_in;
   logic [COUNT_WIDTH-1:0] col_count_ff, col_count_in;
   logic                   checker_ff, checker_in;

   // front stage state
   logic [POS_WIDTH-1:0]   cur_row_ff, cur_row_in;
   logic [POS_WIDTH-1:0]   cur_col_ff, cur_col_in;
   logic [SUM_WIDTH-1:0]   row_sum_ff, row_sum_in;
   logic                   equal_ff, equal_in;
   logic [SUM_WIDTH-1:0]   best_row_sum_ff, best_row_sum_in;
   logic [COUNT_WIDTH-1:0] best_row_idx_ff, best_row_idx_in;

   // column stage
   logic                   s1_valid_ff, s1_valid_in;
   logic [POS_WIDTH-1:0]   s1_idx_ff;
   logic                   s1_first_row_ff;
   logic                   s1_last_row_ff;
   rsp_type                s1_rsp_ff, s1_rsp_in;
   logic [SUM_WIDTH-1:0]   best_col_sum_ff, best_col_sum_in;
   logic [COUNT_WIDTH-1:0] best_col_idx_ff, best_col_idx_in;

   // last write, for forwarding
   logic                   fwd_valid_ff, fwd_valid_in;
   logic [POS_WIDTH-1:0]   fwd_addr_ff;
   logic [SUM_WIDTH-1:0]   fwd_data_ff;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [COUNT_WIDTH-1:0] rows, cols;
   logic                   accept, advance, s1_move;
   logic                   a_bit, last_col, last_row, frame_end, eq_now;
   logic [POS_WIDTH-1:0]   col_idx;
   logic [SUM_WIDTH-1:0]   rsum;
   logic                   row_better;
   logic [SUM_WIDTH-1:0]   ram_rd_data, col_base, csum;
   logic                   col_better;

   assign csr_ready = 1'b1;

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      checker_in   = checker_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ROW_COUNT:    row_count_in = csr_data;
            CSR_COL_COUNT:    col_count_in = csr_data;
            CSR_CHECKER_MODE: checker_in   = csr_data[0];
            default: ;
         endcase
      end
   end

   assign rows = clamp_count(row_count_ff, COUNT_WIDTH'(ROW_LIMIT));
   assign cols = clamp_count(col_count_ff, COUNT_WIDTH'(COL_LIMIT));

   // handshake
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   // front stage
   always_comb begin
      a_bit     = checker_ff ? (cur_row_ff[0] ^ cur_col_ff[0]) : req_data.pixel_a;
      last_col  = {1'b0, cur_col_ff} >= (cols - COUNT_WIDTH'(1));
      last_row  = {1'b0, cur_row_ff} >= (rows - COUNT_WIDTH'(1));
      frame_end = last_col && last_row;
      eq_now    = equal_ff && (a_bit == req_data.pixel_b);
      col_idx   = ({1'b0, cur_col_ff} < cols) ? cur_col_ff
                                              : POS_WIDTH'(cols - COUNT_WIDTH'(1));
      rsum       = row_sum_ff + SUM_WIDTH'(a_bit);
      row_better = last_col && (rsum > best_row_sum_ff);

      best_row_sum_in = row_better ? rsum : best_row_sum_ff;
      best_row_idx_in = row_better ? (COUNT_WIDTH'(cur_row_ff) + COUNT_WIDTH'(1))
                                   : best_row_idx_ff;

      s1_rsp_in.a_used       = a_bit;
      s1_rsp_in.union_bit    = a_bit | req_data.pixel_b;
      s1_rsp_in.diff_bit     = a_bit & ~req_data.pixel_b;
      s1_rsp_in.frame_last   = frame_end;
      s1_rsp_in.images_equal = frame_end && eq_now;
      s1_rsp_in.best_row     = frame_end ? best_row_idx_in : '0;
      s1_rsp_in.best_col     = '0;

      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      row_sum_in = row_sum_ff;
      equal_in   = equal_ff;
      if (accept) begin
         equal_in = eq_now;
         priority if (frame_end) begin
            cur_row_in      = '0;
            cur_col_in      = '0;
            row_sum_in      = '0;
            equal_in        = 1'b1;
            best_row_sum_in = '0;
            best_row_idx_in = '0;
         end else if (last_col) begin
            cur_col_in = '0;
            cur_row_in = cur_row_ff + POS_WIDTH'(1);
            row_sum_in = '0;
         end else begin
            cur_col_in = cur_col_ff + POS_WIDTH'(1);
            row_sum_in = rsum;
         end
      end else begin
         best_row_sum_in = best_row_sum_ff;
         best_row_idx_in = best_row_idx_ff;
      end
   end

   // column sum RAM: read on accept, written when the item leaves stage 1
   bicp_ram #(
      .WIDTH (SUM_WIDTH),
      .DEPTH (COL_DEPTH)
   ) u_col_ram (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_idx_ff),
      .wr_data (csum),
      .rd_en   (accept),
      .rd_addr (col_idx),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      col_base = (fwd_valid_ff && (fwd_addr_ff == s1_idx_ff)) ? fwd_data_ff : ram_rd_data;
      csum     = (s1_first_row_ff ? '0 : col_base) + SUM_WIDTH'(s1_rsp_ff.a_used);
      col_better = s1_last_row_ff && (csum > best_col_sum_ff);

      best_col_sum_in = best_col_sum_ff;
      best_col_idx_in = best_col_idx_ff;
      if (s1_move) begin
         if (s1_rsp_ff.frame_last) begin
            best_col_sum_in = '0;
            best_col_idx_in = '0;
         end else if (col_better) begin
            best_col_sum_in = csum;
            best_col_idx_in = COUNT_WIDTH'(s1_idx_ff) + COUNT_WIDTH'(1);
         end
      end

      rsp_data_in = s1_rsp_ff;
      if (s1_rsp_ff.frame_last) begin
         rsp_data_in.best_col = col_better
            ? (COUNT_WIDTH'(s1_idx_ff) + COUNT_WIDTH'(1)) : best_col_idx_ff;
      end

      s1_valid_in  = accept || (s1_valid_ff && !advance);
      fwd_valid_in = fwd_valid_ff || s1_move;
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= COUNT_WIDTH'(1);
         col_count_ff    <= COUNT_WIDTH'(1);
         checker_ff      <= 1'b0;
         cur_row_ff      <= '0;
         cur_col_ff      <= '0;
         row_sum_ff      <= '0;
         equal_ff        <= 1'b1;
         best_row_sum_ff <= '0;
         best_row_idx_ff <= '0;
         best_col_sum_ff <= '0;
         best_col_idx_ff <= '0;
         s1_valid_ff     <= 1'b0;
         fwd_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         row_count_ff    <= row_count_in;
         col_count_ff    <= col_count_in;
         checker_ff      <= checker_in;
         cur_row_ff      <= cur_row_in;
         cur_col_ff      <= cur_col_in;
         row_sum_ff      <= row_sum_in;
         equal_ff        <= equal_in;
         best_row_sum_ff <= best_row_sum_in;
         best_row_idx_ff <= best_row_idx_in;
         best_col_sum_ff <= best_col_sum_in;
         best_col_idx_ff <= best_col_idx_in;
         s1_valid_ff     <= s1_valid_in;
         fwd_valid_ff    <= fwd_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff       <= col_idx;
         s1_first_row_ff <= (cur_row_ff == '0);
         s1_last_row_ff  <= last_row;
         s1_rsp_ff       <= s1_rsp_in;
      end
      if (s1_move) begin
         fwd_addr_ff <= s1_idx_ff;
         fwd_data_ff <= csum;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("request stalled with room in the pipeline");

   a_accept_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted request missing from column stage");

   a_mid_frame_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.frame_last |->
         rsp_data.best_row == '0 && rsp_data.best_col == '0 && !rsp_data.images_equal)
      else $error("frame result fields set before frame end");

   a_best_col_range: assert property (@(posedge clock) disable iff (reset)
      best_col_idx_ff <= COUNT_WIDTH'(COL_LIMIT))
      else $error("best column index out of range");
`endif

endmodule

/* rtl/bicp_ram.sv */
// ----------------------------------------------------------------------------
// bicp_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bicp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* tb/binary_image_compare_projection_checker.sv */
// ----------------------------------------------------------------------------
// binary_image_compare_projection_checker
// Watches the req, rsp and csr channels of the image compare block. Every
// accepted request is run through a cycle-free model of the raster walk,
// the column sum store and the row / column argmax tracking, and the
// predicted response is queued. Each accepted response is checked field by
// field against the oldest prediction. Reports the failure count and the
// number of predictions still waiting.
// ----------------------------------------------------------------------------
module binary_image_compare_projection_checker
   import bicp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  req_type                  req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  rsp_type                  rsp_data,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [COUNT_WIDTH-1:0]   csr_data,
   output int                       fail_count,
   output int                       outstanding
);

   logic [COUNT_WIDTH-1:0] rows_cfg;
   logic [COUNT_WIDTH-1:0] cols_cfg;
   logic                   pattern_on;

   logic [POS_WIDTH-1:0]   row_pos;
   logic [POS_WIDTH-1:0]   col_pos;
   logic [SUM_WIDTH-1:0]   row_total;
   logic [SUM_WIDTH-1:0]   col_totals [COL_DEPTH];
   logic                   all_match;
   logic [SUM_WIDTH-1:0]   top_row_total;
   logic [COUNT_WIDTH-1:0] top_row;
   logic [SUM_WIDTH-1:0]   top_col_total;
   logic [COUNT_WIDTH-1:0] top_col;

   rsp_type                predicted_pixels [$];
   int                     mismatches;

   function automatic logic [COUNT_WIDTH-1:0] used_count(
      input logic [COUNT_WIDTH-1:0] cfg,
      input int                     lim
   );
      int hi;
      hi = (lim < 128) ? lim : 128;
      if (cfg == '0) begin
         return COUNT_WIDTH'(1);
      end
      if (int'(cfg) > hi) begin
         return COUNT_WIDTH'(hi);
      end
      return cfg;
   endfunction

   task automatic clear_frame();
      row_pos       = '0;
      col_pos       = '0;
      row_total     = '0;
      all_match     = 1'b1;
      top_row_total = '0;
      top_row       = '0;
      top_col_total = '0;
      top_col       = '0;
   endtask

   task automatic predict_pixel(input req_type px, output rsp_type res);
      logic [COUNT_WIDTH-1:0] rows;
      logic [COUNT_WIDTH-1:0] cols;
      logic                   a;
      logic                   b;
      logic                   end_col;
      logic                   end_row;
      logic                   end_frame;
      logic [POS_WIDTH-1:0]   cidx;
      logic [SUM_WIDTH-1:0]   csum;
      rows = used_count(rows_cfg, MAX_ROWS);
      cols = used_count(cols_cfg, MAX_COLS);
      b = px.pixel_b;
      a = pattern_on ? (row_pos[0] ^ col_pos[0]) : px.pixel_a;
      end_col   = {1'b0, col_pos} >= (cols - COUNT_WIDTH'(1));
      end_row   = {1'b0, row_pos} >= (rows - COUNT_WIDTH'(1));
      end_frame = end_col && end_row;
      if (a != b) begin
         all_match = 1'b0;
      end
      // first row of a frame starts the column sums afresh
      cidx = ({1'b0, col_pos} < cols) ? col_pos : POS_WIDTH'(cols - COUNT_WIDTH'(1));
      csum = ((row_pos == '0) ? SUM_WIDTH'(0) : col_totals[cidx]) + SUM_WIDTH'(a);
      col_totals[cidx] = csum;
      if (end_row && csum > top_col_total) begin
         top_col_total = csum;
         top_col       = {1'b0, cidx} + COUNT_WIDTH'(1);
      end
      row_total = row_total + SUM_WIDTH'(a);
      if (end_col && row_total > top_row_total) begin
         top_row_total = row_total;
         top_row       = {1'b0, row_pos} + COUNT_WIDTH'(1);
      end
      res.a_used       = a;
      res.union_bit    = a | b;
      res.diff_bit     = a & ~b;
      res.frame_last   = end_frame;
      res.images_equal = end_frame ? all_match : 1'b0;
      res.best_row     = end_frame ? top_row : '0;
      res.best_col     = end_frame ? top_col : '0;
      if (end_frame) begin
         clear_frame();
      end else if (end_col) begin
         col_pos   = '0;
         row_pos   = row_pos + POS_WIDTH'(1);
         row_total = '0;
      end else begin
         col_pos = col_pos + POS_WIDTH'(1);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rows_cfg   = COUNT_WIDTH'(1);
         cols_cfg   = COUNT_WIDTH'(1);
         pattern_on = 1'b0;
         for (int i = 0; i < COL_DEPTH; i++) begin
            col_totals[i] = '0;
         end
         clear_frame();
         predicted_pixels.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected response: a=%0d u=%0d d=%0d last=%0d eq=%0d row=%0d col=%0d",
                           rsp_data.a_used, rsp_data.union_bit, rsp_data.diff_bit,
                           rsp_data.frame_last, rsp_data.images_equal,
                           rsp_data.best_row, rsp_data.best_col);
               end
            end else begin
               want = predicted_pixels.pop_front();
               if (rsp_data.a_used !== want.a_used ||
                   rsp_data.union_bit !== want.union_bit ||
                   rsp_data.diff_bit !== want.diff_bit ||
                   rsp_data.frame_last !== want.frame_last ||
                   rsp_data.images_equal !== want.images_equal ||
                   rsp_data.best_row !== want.best_row ||
                   rsp_data.best_col !== want.best_col) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: expected a=%0d u=%0d d=%0d last=%0d eq=%0d row=%0d col=%0d",
                              want.a_used, want.union_bit, want.diff_bit, want.frame_last,
                              want.images_equal, want.best_row, want.best_col);
                     $display("          actual   a=%0d u=%0d d=%0d last=%0d eq=%0d row=%0d col=%0d",
                              rsp_data.a_used, rsp_data.union_bit, rsp_data.diff_bit,
                              rsp_data.frame_last, rsp_data.images_equal,
                              rsp_data.best_row, rsp_data.best_col);
                  end
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROW_COUNT: begin
                  rows_cfg = csr_data;
               end
               CSR_COL_COUNT: begin
                  cols_cfg = csr_data;
               end
               CSR_CHECKER_MODE: begin
                  pattern_on = csr_data[0];
               end
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            predict_pixel(req_data, want);
            predicted_pixels.push_back(want);
         end
      end
      outstanding <= predicted_pixels.size();
      fail_count  <= mismatches;
   end

endmodule

/* tb/tb_binary_image_compare_projection.sv */
// ----------------------------------------------------------------------------
// tb_binary_image_compare_projection
// Drives pixel pairs and register writes into the image compare block with
// random idle cycles on both handshakes. A directed opening covers empty
// and matching images, every pixel combination, the checkerboard mode,
// zero counts, an unmapped register and a size change that ends a frame
// early; random phases then change frame size, mode and pixel mix. At least
// once the response side holds off while requests keep coming. A separate
// checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_binary_image_compare_projection;
   import bicp_pkg::*;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SPARE = 2'd3;
   localparam int STALL_LIMIT  = 1000;
   localparam int HOLD_CYCLES  = 90;
   localparam int RANDOM_ITEMS = 1100;

   typedef enum int {MIX_RANDOM, MIX_BLANK_A, MIX_SAME, MIX_SPARSE} pixel_mix_type;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_type                  req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_WIDTH-1:0] csr_index = '0;
   logic [COUNT_WIDTH-1:0]   csr_data  = '0;

   int fail_count;
   int outstanding;
   int idle_cycles = 0;
   bit send_burst  = 1'b0;
   bit recv_burst  = 1'b0;
   bit hold_rsp    = 1'b0;

   binary_image_compare_projection uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   binary_image_compare_projection_checker monitor (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #6 clock = ~clock;

   function automatic int draw_gap(input bit burst);
      if (burst || $urandom_range(0, 2) == 0) begin
         return 0;
      end
      return $urandom_range(0, 11);
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] pick_count();
      int r;
      r = $urandom_range(0, 39);
      if (r == 0) begin
         return '0;
      end else if (r == 1) begin
         return COUNT_WIDTH'($urandom_range(129, 255));
      end else if (r == 2) begin
         return COUNT_WIDTH'(128);
      end else if (r < 8) begin
         return COUNT_WIDTH'($urandom_range(7, 20));
      end
      return COUNT_WIDTH'($urandom_range(1, 6));
   endfunction

   function automatic int span(input logic [COUNT_WIDTH-1:0] cfg);
      if (cfg == '0) begin
         return 1;
      end
      if (int'(cfg) > COL_LIMIT) begin
         return COL_LIMIT;
      end
      return int'(cfg);
   endfunction

   // leaves req_valid high after acceptance; next send or drain decides
   task automatic send_pixel(input logic a, input logic b);
      int gap;
      gap = draw_gap(send_burst);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data.pixel_a <= a;
      req_data.pixel_b <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_reg(
      input logic [CSR_IDX_WIDTH-1:0] idx,
      input logic [COUNT_WIDTH-1:0]   val,
      input bit                       last
   );
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (last) begin
         csr_valid <= 1'b0;
      end
   endtask

   task automatic configure(
      input logic [COUNT_WIDTH-1:0] rows,
      input logic [COUNT_WIDTH-1:0] cols,
      input logic                   mode
   );
      write_reg(CSR_ROW_COUNT, rows, 1'b0);
      write_reg(CSR_COL_COUNT, cols, 1'b0);
      write_reg(CSR_CHECKER_MODE, {7'($urandom), mode}, 1'b1);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // response side
   initial begin
      int gap;
      int served;
      served = 0;
      while (reset) @(posedge clock);
      forever begin
         if (served % 64 == 0) begin
            recv_burst = ($urandom_range(0, 3) == 0);
         end
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = draw_gap(recv_burst);
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         served++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int                     n;
      int                     sent;
      int                     phase;
      int                     frame_px;
      pixel_mix_type          mix;
      logic [COUNT_WIDTH-1:0] rows_v;
      logic [COUNT_WIDTH-1:0] cols_v;
      logic                   mode_v;
      logic                   a;
      logic                   b;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // one full-width row first so every column sum entry holds a value
      configure(8'd1, 8'd128, 1'b0);
      for (int i = 0; i < 128; i++) begin
         send_pixel(i == 127, 1'($urandom_range(0, 1)));
      end
      drain();

      // empty A with matching B, then every a/b combination
      configure(8'd2, 8'd2, 1'b0);
      repeat (4) send_pixel(1'b0, 1'b0);
      send_pixel(1'b1, 1'b0);
      send_pixel(1'b1, 1'b1);
      send_pixel(1'b0, 1'b1);
      send_pixel(1'b1, 1'b1);
      drain();

      // checkerboard replaces A
      configure(8'd2, 8'd3, 1'b1);
      repeat (6) send_pixel(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      drain();

      // zero counts act as one; unmapped register is ignored
      write_reg(CSR_SPARE, 8'hff, 1'b0);
      configure(8'd0, 8'd0, 1'b0);
      send_pixel(1'b1, 1'b1);
      drain();

      // shrink mid-frame: position already past the new bounds
      configure(8'd3, 8'd3, 1'b0);
      repeat (5) send_pixel(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      drain();
      configure(8'd2, 8'd2, 1'b0);
      send_pixel(1'b1, 1'b0);

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         drain();
         rows_v = pick_count();
         cols_v = (rows_v > 8'd6) ? COUNT_WIDTH'($urandom_range(0, 3)) : pick_count();
         mode_v = ($urandom_range(0, 2) == 0);
         configure(rows_v, cols_v, mode_v);
         frame_px = span(rows_v) * span(cols_v);
         n = frame_px * ((frame_px > 64) ? 1 : $urandom_range(1, 3)) + $urandom_range(0, 3);
         if (n > RANDOM_ITEMS - sent) begin
            n = RANDOM_ITEMS - sent;
         end
         mix = pixel_mix_type'($urandom_range(0, 3));
         send_burst = ($urandom_range(0, 3) == 0);
         if (phase == 1 || phase == 20) begin
            hold_rsp   = 1'b1;
            send_burst = 1'b1;
            n += 24;
         end
         repeat (n) begin
            case (mix)
               MIX_RANDOM: begin
                  a = 1'($urandom_range(0, 1));
                  b = 1'($urandom_range(0, 1));
               end
               MIX_BLANK_A: begin
                  a = 1'b0;
                  b = ($urandom_range(0, 3) == 0);
               end
               MIX_SAME: begin
                  a = 1'($urandom_range(0, 1));
                  b = a;
               end
               default: begin
                  a = ($urandom_range(0, 7) == 0);
                  b = ($urandom_range(0, 15) == 0) ? ~a : a;
               end
            endcase
            send_pixel(a, b);
         end
         sent += n;
         phase++;
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
